// ===== hdl/mspwm_pkg.sv =====
// ============================================================================
// mspwm_pkg : shared types and constants of the software PWM channel table
// Field widths, action codes, controller states and the command and status
// bundles that join the controller to the datapath.
// ============================================================================
`default_nettype none

package mspwm_pkg;

   localparam int ACT_W = 2;
   localparam int PIN_W = 8;
   localparam int CNT_W = 16;
   localparam int LIM_W = 32;

   typedef enum logic [ACT_W-1:0] {
      ACT_TICK    = 2'd0,
      ACT_ASSIGN  = 2'd1,
      ACT_UPDATE  = 2'd2,
      ACT_RELEASE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_FLUSH
   } state_type;

   // One row of the channel table memory.
   typedef struct packed {
      logic [PIN_W-1:0] pin;
      logic [CNT_W-1:0] count;
      logic [CNT_W-1:0] period;
      logic [CNT_W-1:0] term;
      logic [LIM_W-1:0] remaining;
   } entry_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;   // capture the request beat and rewind the entry index
      logic exec;   // apply the action to the current entry
      logic step;   // advance to the next entry
      logic flush;  // move the held result to the output register as the last beat
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      action_type act;
      logic       hit;         // search action matched the current entry
      logic       res;         // current entry yields a result beat
      logic       last_idx;    // current entry is the final one of the table
      logic       pend_valid;  // a result is held back waiting for its successor
      logic       out_free;    // output register can take a beat this cycle
   } status_type;

endpackage

`default_nettype wire

// ===== hdl/mspwm_if.sv =====
// ============================================================================
// mspwm_if : request and response channel interfaces
// Valid/ready channels carrying the request and result beats of the table.
// ============================================================================
`default_nettype none

interface mspwm_req_if
   import mspwm_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [ACT_W-1:0] action;
   logic [PIN_W-1:0] pin;
   logic [CNT_W-1:0] period;
   logic [CNT_W-1:0] duty_term;
   logic [LIM_W-1:0] tick_limit;

   modport source (output valid, action, pin, period, duty_term, tick_limit,
                   input ready);
   modport sink (input valid, action, pin, period, duty_term, tick_limit,
                 output ready);
endinterface

interface mspwm_rsp_if
   import mspwm_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [PIN_W-1:0] pin_res;
   logic             level;
   logic             last;

   modport source (output valid, pin_res, level, last, input ready);
   modport sink (input valid, pin_res, level, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/mspwm_ctrl.sv =====
// ============================================================================
// mspwm_ctrl : sequencing controller of the channel table
// Walks the table one entry per read/execute pair and drains the held result.
// ============================================================================
`default_nettype none

module mspwm_ctrl
   import mspwm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire status_type st,
   output      cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            // A new result needs the held one to leave first.
            if (!(st.res && st.pend_valid && !st.out_free)) begin
               cmd.exec = 1'b1;
               if ((st.act != ACT_TICK && st.hit) || st.last_idx) begin
                  state_in = ST_FLUSH;
               end else begin
                  cmd.step = 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         ST_FLUSH: begin
            if (!st.pend_valid) begin
               state_in = ST_IDLE;
            end else if (st.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/mspwm_dp.sv =====
// ============================================================================
// mspwm_dp : datapath of the channel table
// Table memory, per-entry valid and assigned flags, entry update logic, the
// held result and the output register.
// ============================================================================
`default_nettype none

module mspwm_dp
   import mspwm_pkg::*;
#(
   parameter int CHANNELS = 20
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cmd_type          cmd,
   output      status_type       st,
   input  wire logic [ACT_W-1:0] req_action,
   input  wire logic [PIN_W-1:0] req_pin,
   input  wire logic [CNT_W-1:0] req_period,
   input  wire logic [CNT_W-1:0] req_duty_term,
   input  wire logic [LIM_W-1:0] req_tick_limit,
   input  wire logic             rsp_ready,
   output      logic             rsp_valid,
   output      logic [PIN_W-1:0] rsp_pin_res,
   output      logic             rsp_level,
   output      logic             rsp_last
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   entry_type mem [CHANNELS];
   entry_type rd_ff;

   action_type       act_ff;
   logic [PIN_W-1:0] pin_ff;
   logic [CNT_W-1:0] period_ff;
   logic [CNT_W-1:0] term_ff;
   logic [LIM_W-1:0] limit_ff;

   logic [IDX_W-1:0]    idx_ff;
   logic [CHANNELS-1:0] valid_ff;
   logic [CHANNELS-1:0] assigned_ff;

   logic             pend_valid_ff;
   logic [PIN_W-1:0] pend_pin_ff;
   logic             pend_level_ff;

   logic             out_valid_ff;
   logic [PIN_W-1:0] out_pin_ff;
   logic             out_level_ff;
   logic             out_last_ff;

   logic             cur_valid;
   logic             cur_assigned;
   logic             pin_eq;
   logic             hit;
   logic             res;
   logic             res_level;
   logic [PIN_W-1:0] res_pin;
   logic [CNT_W-1:0] cnt_inc;
   logic [CNT_W-1:0] cnt_next;
   logic [LIM_W-1:0] rem_next;
   logic             expire;
   logic             we;
   entry_type        wr;
   logic             out_free;
   logic             push_mid;

   assign cur_valid    = valid_ff[idx_ff];
   assign cur_assigned = assigned_ff[idx_ff];
   assign pin_eq       = (rd_ff.pin == pin_ff);

   assign cnt_inc  = rd_ff.count + 1'b1;
   assign cnt_next = (cnt_inc >= rd_ff.period) ? '0 : cnt_inc;
   assign expire   = (rd_ff.remaining == LIM_W'(1));
   assign rem_next = (rd_ff.remaining != '0) ? rd_ff.remaining - 1'b1 : rd_ff.remaining;

   always_comb begin
      hit       = 1'b0;
      res       = 1'b0;
      res_level = 1'b0;
      res_pin   = rd_ff.pin;
      we        = 1'b0;
      wr        = rd_ff;
      unique case (act_ff)
         ACT_TICK: begin
            // Term wins over the start of a period.
            res       = cur_valid && ((rd_ff.count == rd_ff.term) || (rd_ff.count == '0));
            res_level = (rd_ff.count != rd_ff.term);
            we        = cur_valid;
            wr.count     = cnt_next;
            wr.remaining = rem_next;
         end
         ACT_ASSIGN: begin
            hit = !cur_valid || (cur_assigned && pin_eq);
            we  = hit;
            wr.pin       = pin_ff;
            wr.count     = '0;
            wr.period    = period_ff;
            wr.term      = term_ff;
            wr.remaining = limit_ff;
         end
         ACT_UPDATE: begin
            hit = cur_assigned && pin_eq;
            we  = hit;
            wr.period    = period_ff;
            wr.term      = term_ff;
            wr.remaining = limit_ff;
         end
         ACT_RELEASE: begin
            hit       = cur_valid && pin_eq;
            res       = hit;
            res_level = 1'b0;
            res_pin   = pin_ff;
         end
         default: begin
            hit = 1'b0;
         end
      endcase
   end

   assign out_free = !out_valid_ff || rsp_ready;
   assign push_mid = cmd.exec && res && pend_valid_ff;

   assign st.act        = act_ff;
   assign st.hit        = hit;
   assign st.res        = res;
   assign st.last_idx   = (idx_ff == IDX_W'(CHANNELS - 1));
   assign st.pend_valid = pend_valid_ff;
   assign st.out_free   = out_free;

   assign rsp_valid   = out_valid_ff;
   assign rsp_pin_res = out_pin_ff;
   assign rsp_level   = out_level_ff;
   assign rsp_last    = out_last_ff;

   // Table memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cmd.exec && we) begin
         mem[idx_ff] <= wr;
      end
      rd_ff <= mem[idx_ff];
   end

   // Request capture and result payloads.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff    <= action_type'(req_action);
         pin_ff    <= req_pin;
         period_ff <= req_period;
         term_ff   <= req_duty_term;
         limit_ff  <= req_tick_limit;
      end
      if (cmd.exec && res) begin
         pend_pin_ff   <= res_pin;
         pend_level_ff <= res_level;
      end
      if (push_mid || cmd.flush) begin
         out_pin_ff   <= pend_pin_ff;
         out_level_ff <= pend_level_ff;
         out_last_ff  <= cmd.flush;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         valid_ff      <= '0;
         assigned_ff   <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.load) begin
            idx_ff <= '0;
         end else if (cmd.step) begin
            idx_ff <= idx_ff + 1'b1;
         end

         if (cmd.exec) begin
            unique case (act_ff)
               ACT_TICK: begin
                  if (cur_valid && expire) begin
                     valid_ff[idx_ff] <= 1'b0;
                  end
               end
               ACT_ASSIGN: begin
                  if (hit) begin
                     valid_ff[idx_ff]    <= 1'b1;
                     assigned_ff[idx_ff] <= 1'b1;
                  end
               end
               ACT_UPDATE: begin
                  if (hit) begin
                     valid_ff[idx_ff] <= 1'b1;
                  end
               end
               ACT_RELEASE: begin
                  if (hit) begin
                     valid_ff[idx_ff]    <= 1'b0;
                     assigned_ff[idx_ff] <= 1'b0;
                  end
               end
               default: begin
                  valid_ff <= valid_ff;
               end
            endcase
         end

         if (cmd.exec && res) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end

         if (push_mid || cmd.flush) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/multichannel_software_pwm_table.sv =====
// ============================================================================
// multichannel_software_pwm_table : table of software PWM channels
// Keeps up to CHANNELS PWM channels, each bound to a pin. A tick reports the
// pin levels that change at period start and term; a release reports low.
// ============================================================================
//
//   Channel   Direction  Beat contents                           Handshake
//   req_chan  in         action, pin, period, duty_term,         valid/ready
//                        tick_limit
//   rsp_chan  out        pin_res, level, last                    valid/ready
//
// Every action walks the table one entry at a time, with a read state that
// fetches the row from the table memory and an execute state that updates it.
// A tick visits all CHANNELS entries; assign, update and release stop at the
// first matching entry, or visit all CHANNELS entries when nothing matches.
// Reset clears all valid and assigned flags at once; the table rows need none.
// A stalled result channel holds the walk only when an entry yields a result
// while another one is already held and the output register is still full.
// The closing flush of the held result also waits for the output register,
// so a stall in either place holds the item back.
//
`default_nettype none

module multichannel_software_pwm_table
   import mspwm_pkg::*;
#(
   parameter int CHANNELS = 20
) (
   input wire logic   clock,
   input wire logic   reset,
   mspwm_req_if.sink  req_chan,
   mspwm_rsp_if.source rsp_chan
);

   cmd_type    cmd;
   status_type st;

   // The controller decides what happens each cycle: it takes a request beat
   // only when idle, steps the entry index through read and execute phases,
   // and finally drains the held result as the last beat of the item.
   mspwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .st        (st),
      .cmd       (cmd)
   );

   // The datapath owns the table and the result registers. Each tick result
   // is held back one step so that the last beat can be marked once the walk
   // knows no further result follows.
   mspwm_dp #(
      .CHANNELS (CHANNELS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .st             (st),
      .req_action     (req_chan.action),
      .req_pin        (req_chan.pin),
      .req_period     (req_chan.period),
      .req_duty_term  (req_chan.duty_term),
      .req_tick_limit (req_chan.tick_limit),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_pin_res    (rsp_chan.pin_res),
      .rsp_level      (rsp_chan.level),
      .rsp_last       (rsp_chan.last)
   );

endmodule

`default_nettype wire

// ===== hdl/mspwm_checker.sv =====
// ============================================================================
// mspwm_checker : port-level checks of the PWM channel table
// Watches the request and result channels and flags ordering slips.
// ============================================================================
`default_nettype none

module mspwm_checker
   import mspwm_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [PIN_W-1:0] rsp_pin_res,
   input wire logic             rsp_level,
   input wire logic             rsp_last
);

   // A stalled result beat keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pin_res)
         && $stable(rsp_level) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   // Each request needs at least a read and an execute state before the next.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("request taken again too early");

   // No result can appear right after a request is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result beat appeared without a table access");

   // While a non-final beat waits, the item is still in work.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("new request accepted before the last beat of an item");

endmodule

bind multichannel_software_pwm_table mspwm_checker u_mspwm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_pin_res (rsp_chan.pin_res),
   .rsp_level   (rsp_chan.level),
   .rsp_last    (rsp_chan.last)
);

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb : self-checking bench for the software PWM channel table
// Sends tick, assign, update and release beats over the request channel and
// checks every pin write on the response channel against a cycle-free model
// of the channel table. Both channels idle and stall at random.
// ============================================================================

module tb;
   import mspwm_pkg::*;

   localparam int CHANNELS    = 20;
   // Length of a full table walk; SETTLE allows generous slack.
   localparam int WALK_CYCLES = 2 * CHANNELS + 2;
   localparam int SETTLE      = 3 * WALK_CYCLES;
   localparam int NUM_CMDS    = 230;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int MAX_GAP     = 18;

   // One request beat plus the idle cycles that precede it on the channel.
   typedef struct packed {
      action_type       act;
      logic [PIN_W-1:0] pin;
      logic [CNT_W-1:0] period;
      logic [CNT_W-1:0] term;
      logic [LIM_W-1:0] lim;
      logic [4:0]       gap;
      logic             drain;  // hold this beat until no pin write is due
   } pwm_cmd_t;

   // One pin write as seen on the response channel.
   typedef struct packed {
      logic [PIN_W-1:0] pin;
      logic             level;
      logic             last;
   } pin_write_t;

   logic clock;
   logic reset;

   mspwm_req_if req_chan ();
   mspwm_rsp_if rsp_chan ();

   multichannel_software_pwm_table #(
      .CHANNELS (CHANNELS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // -------------------------------------------------------------------------
   // Shadow copy of the channel table. Every entry starts free and unowned;
   // data fields are only read from entries that were written before.
   // -------------------------------------------------------------------------
   bit               ch_on    [CHANNELS];
   bit               ch_owned [CHANNELS];
   bit [PIN_W-1:0]   ch_pin   [CHANNELS];
   bit [CNT_W-1:0]   ch_phase [CHANNELS];
   bit [CNT_W-1:0]   ch_period[CHANNELS];
   bit [CNT_W-1:0]   ch_term  [CHANNELS];
   bit [LIM_W-1:0]   ch_left  [CHANNELS];

   pwm_cmd_t   req_backlog[$];       // beats not yet offered to the block
   pin_write_t level_writes_due[$];  // pin writes predicted but not yet seen
   pwm_cmd_t   beat_in_flight;       // the beat currently on the request bus

   int  cmds_queued;
   int  accepted_count;
   int  mismatches;
   int  cycle_count;
   bit  sender_calm;
   bit  sink_calm;
   bit  drain_next;
   bit  gap_armed;
   int  gap_left;
   int  stall_left;

   // Idle cycles before a beat: none in a calm stretch, otherwise at least half
   // the beats go straight through and the rest draw a gap of at most MAX_GAP.
   function automatic int draw_gap(input bit calm);
      if (calm || $urandom_range(0, 1) == 0)
         return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   // Appends one beat to the backlog. A pending pause request is attached to
   // the beat and then consumed.
   task automatic queue_cmd(input action_type a, input logic [PIN_W-1:0] p,
                            input logic [CNT_W-1:0] per, input logic [CNT_W-1:0] trm,
                            input logic [LIM_W-1:0] lim);
      pwm_cmd_t c;
      c.act    = a;
      c.pin    = p;
      c.period = per;
      c.term   = trm;
      c.lim    = lim;
      c.gap    = 5'(draw_gap(sender_calm));
      c.drain  = drain_next;
      drain_next = 1'b0;
      req_backlog.push_back(c);
      cmds_queued++;
   endtask

   // Appends one beat whose payload fields are all random.
   task automatic queue_noise(input action_type a);
      queue_cmd(a, PIN_W'($urandom), CNT_W'($urandom), CNT_W'($urandom), $urandom);
   endtask

   // Applies one accepted beat to the shadow table and queues the pin writes
   // it causes, marking the final one of the beat.
   task automatic apply_pwm_action(input pwm_cmd_t c);
      bit [PIN_W-1:0] hit_pins[CHANNELS];
      bit             hit_lvls[CHANNELS];
      int             n;
      bit [CNT_W-1:0] nxt;
      pin_write_t     w;
      n = 0;
      case (c.act)
         ACT_TICK: begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (ch_on[i]) begin
                  // The term test wins over the period start.
                  if (ch_phase[i] == ch_term[i]) begin
                     hit_pins[n] = ch_pin[i];
                     hit_lvls[n] = 1'b0;
                     n++;
                  end else if (ch_phase[i] == '0) begin
                     hit_pins[n] = ch_pin[i];
                     hit_lvls[n] = 1'b1;
                     n++;
                  end
                  // A limit of zero runs forever; counting down to zero stops
                  // the channel but leaves it owned.
                  if (ch_left[i] != '0) begin
                     ch_left[i] = ch_left[i] - 1'b1;
                     if (ch_left[i] == '0)
                        ch_on[i] = 1'b0;
                  end
                  nxt = ch_phase[i] + 1'b1;
                  ch_phase[i] = (nxt >= ch_period[i]) ? '0 : nxt;
               end
            end
         end
         ACT_ASSIGN: begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (!ch_on[i] || (ch_owned[i] && ch_pin[i] == c.pin)) begin
                  ch_pin[i]    = c.pin;
                  ch_phase[i]  = '0;
                  ch_period[i] = c.period;
                  ch_term[i]   = c.term;
                  ch_left[i]   = c.lim;
                  ch_on[i]     = 1'b1;
                  ch_owned[i]  = 1'b1;
                  break;
               end
            end
         end
         ACT_UPDATE: begin
            // Only owned entries match, so a stopped channel can be revived.
            for (int i = 0; i < CHANNELS; i++) begin
               if (ch_owned[i] && ch_pin[i] == c.pin) begin
                  ch_period[i] = c.period;
                  ch_term[i]   = c.term;
                  ch_left[i]   = c.lim;
                  ch_on[i]     = 1'b1;
                  break;
               end
            end
         end
         ACT_RELEASE: begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (ch_on[i] && ch_pin[i] == c.pin) begin
                  ch_on[i]    = 1'b0;
                  ch_owned[i] = 1'b0;
                  hit_pins[n] = c.pin;
                  hit_lvls[n] = 1'b0;
                  n++;
                  break;
               end
            end
         end
      endcase
      for (int k = 0; k < n; k++) begin
         w.pin   = hit_pins[k];
         w.level = hit_lvls[k];
         w.last  = (k == n - 1);
         level_writes_due.push_back(w);
      end
   endtask

   task automatic log_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   // -------------------------------------------------------------------------
   // Clock, reset and time-zero values on every input of the block.
   // -------------------------------------------------------------------------
   always #6 clock = ~clock;

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.action      = '0;
      req_chan.pin         = '0;
      req_chan.period      = '0;
      req_chan.duty_term   = '0;
      req_chan.tick_limit  = '0;
      rsp_chan.ready       = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // -------------------------------------------------------------------------
   // Request driver. A beat is taken from the backlog only when the bus is
   // free; its idle gap is counted out first, and a beat marked for draining
   // waits until every predicted pin write has been seen. The accepted beat
   // is fed to the shadow table on the edge where the handshake completes.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         gap_armed = 1'b0;
         gap_left  = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            apply_pwm_action(beat_in_flight);
            accepted_count++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (req_backlog.size() == 0) begin
               req_chan.valid <= 1'b0;
            end else begin
               if (!gap_armed) begin
                  gap_left  = int'(req_backlog[0].gap);
                  gap_armed = 1'b1;
               end
               if (gap_left != 0) begin
                  gap_left--;
                  req_chan.valid <= 1'b0;
               end else if (req_backlog[0].drain && level_writes_due.size() != 0) begin
                  req_chan.valid <= 1'b0;
               end else begin
                  beat_in_flight = req_backlog.pop_front();
                  gap_armed      = 1'b0;
                  req_chan.action     <= beat_in_flight.act;
                  req_chan.pin        <= beat_in_flight.pin;
                  req_chan.period     <= beat_in_flight.period;
                  req_chan.duty_term  <= beat_in_flight.term;
                  req_chan.tick_limit <= beat_in_flight.lim;
                  req_chan.valid      <= 1'b1;
               end
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response monitor. Every accepted beat is matched against the oldest
   // predicted pin write. Ready drops for a random number of cycles after
   // each beat, with occasional calm stretches where it stays high.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      pin_write_t want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (level_writes_due.size() == 0) begin
               log_mismatch($sformatf("unexpected beat pin %0d level %0d last %0d",
                                      rsp_chan.pin_res, rsp_chan.level, rsp_chan.last));
            end else begin
               want = level_writes_due.pop_front();
               if (rsp_chan.pin_res !== want.pin || rsp_chan.level !== want.level ||
                   rsp_chan.last !== want.last)
                  log_mismatch($sformatf(
                     "expected pin %0d level %0d last %0d, got pin %0d level %0d last %0d",
                     want.pin, want.level, want.last,
                     rsp_chan.pin_res, rsp_chan.level, rsp_chan.last));
            end
            if ($urandom_range(0, 29) == 0)
               sink_calm = !sink_calm;
            stall_left = draw_gap(sink_calm);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL multichannel_software_pwm_table");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus plan and end of run.
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int               r;
      bit               fill_done;
      logic [CNT_W-1:0] per;
      logic [CNT_W-1:0] trm;
      logic [LIM_W-1:0] lim;
      logic [PIN_W-1:0] p;

      // Directed opening. Period zero holds the count at zero, so with term
      // zero the term test fires every tick.
      queue_cmd(ACT_ASSIGN, 8'd0, 16'd0, 16'd0, 32'd0);
      // All-ones fields: long period, and a term at the period is never reached.
      queue_cmd(ACT_ASSIGN, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      queue_cmd(ACT_ASSIGN, 8'h5A, 16'd4, 16'd2, 32'd0);
      repeat (3) queue_noise(ACT_TICK);
      // Update keeps the running count of the entry.
      queue_cmd(ACT_UPDATE, 8'h5A, 16'd3, 16'd0, 32'd0);
      // Update and release of a pin that owns no entry are dropped.
      queue_cmd(ACT_UPDATE, 8'hA5, 16'd7, 16'd1, 32'd5);
      queue_cmd(ACT_TICK, 8'h00, 16'h0000, 16'h0000, 32'h0);
      drain_next = 1'b1;
      queue_cmd(ACT_RELEASE, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      queue_cmd(ACT_RELEASE, 8'h77, 16'd0, 16'd0, 32'd0);
      // Assign to a pin that already owns an entry restarts that entry.
      queue_cmd(ACT_ASSIGN, 8'd0, 16'd2, 16'd1, 32'd3);
      repeat (4) queue_noise(ACT_TICK);
      // The limit has run out: release skips the stopped entry, update
      // revives it. Term at the period is never reached.
      queue_cmd(ACT_RELEASE, 8'd0, 16'd0, 16'd0, 32'd0);
      queue_cmd(ACT_UPDATE, 8'd0, 16'd5, 16'd5, 32'd2);
      queue_cmd(ACT_TICK, 8'd0, 16'd0, 16'd0, 32'd0);
      // A one-tick channel; assign of the same pin then takes the first stopped entry.
      queue_cmd(ACT_ASSIGN, 8'h33, 16'd1, 16'd9, 32'd1);
      repeat (2) queue_noise(ACT_TICK);
      queue_cmd(ACT_ASSIGN, 8'h33, 16'd3, 16'd1, 32'd0);
      queue_cmd(ACT_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);

      // Random part, built from short sequences. Most are bursts that assign
      // a few channels on a small pin pool, tick them, and then may update or
      // release; a few fill the table past its size; the rest is noise with
      // every field random.
      fill_done = 1'b0;
      while (cmds_queued < NUM_CMDS) begin
         sender_calm = ($urandom_range(0, 3) == 0);
         drain_next  = ($urandom_range(0, 14) == 0);
         r = $urandom_range(0, 99);
         if ((!fill_done && cmds_queued > 120) || r < 3) begin
            fill_done = 1'b1;
            for (int k = 0; k <= CHANNELS; k++)
               queue_cmd(ACT_ASSIGN, PIN_W'(8'hC0 + k), CNT_W'($urandom_range(0, 6)),
                         CNT_W'($urandom_range(0, 6)), 32'd0);
            repeat (2) queue_noise(ACT_TICK);
            for (int k = 0; k <= CHANNELS; k++)
               queue_cmd(ACT_RELEASE, PIN_W'(8'hC0 + k), CNT_W'($urandom),
                         CNT_W'($urandom), $urandom);
         end else if (r < 13) begin
            repeat ($urandom_range(1, 3))
               queue_noise(action_type'($urandom_range(0, 3)));
         end else begin
            repeat ($urandom_range(1, 4)) begin
               p = PIN_W'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 7));
               per = CNT_W'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 10));
               trm = CNT_W'(($urandom_range(0, 7) == 0) ? $urandom
                                                       : $urandom_range(0, per + 1));
               r = $urandom_range(0, 99);
               lim = (r < 40) ? 32'd0 : (r < 85) ? $urandom_range(1, 24) : $urandom;
               queue_cmd(ACT_ASSIGN, p, per, trm, lim);
            end
            repeat ($urandom_range(2, 8))
               queue_noise(ACT_TICK);
            if ($urandom_range(0, 1) == 0) begin
               per = CNT_W'($urandom_range(0, 10));
               r = $urandom_range(0, 2);
               lim = (r == 0) ? 32'd0 : (r == 1) ? $urandom_range(1, 24) : $urandom;
               queue_cmd(ACT_UPDATE, PIN_W'($urandom_range(0, 7)), per,
                         CNT_W'($urandom_range(0, per + 1)), lim);
            end
            repeat ($urandom_range(0, 4))
               queue_noise(ACT_TICK);
            if ($urandom_range(0, 2) == 0)
               queue_cmd(ACT_RELEASE, PIN_W'($urandom_range(0, 7)), CNT_W'($urandom),
                         CNT_W'($urandom), $urandom);
         end
      end

      // Wait for every beat to be taken and every pin write to be seen, then
      // wait out SETTLE to show any stray beat.
      @(negedge reset);
      while (accepted_count < cmds_queued || level_writes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (mismatches == 0 && level_writes_due.size() == 0) begin
         $display("PASS multichannel_software_pwm_table");
      end else begin
         $display("FAIL multichannel_software_pwm_table");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/mspwm_pkg.sv
hdl/mspwm_if.sv
hdl/mspwm_ctrl.sv
hdl/mspwm_dp.sv
hdl/multichannel_software_pwm_table.sv
hdl/mspwm_checker.sv
test/tb.sv
